>>> hw/rtl/ggv_pkg.sv
package ggv_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GOAL_X       = 2'd0,
        CFG_GOAL_Y       = 2'd1,
        CFG_LINEAR_GAIN  = 2'd2,
        CFG_ANGULAR_GAIN = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Datapath widths.
    localparam int unsigned POS_W   = 32;
    localparam int unsigned ERR_W   = 33;
    localparam int unsigned XY_W    = 36;
    localparam int unsigned ANG_W   = 32;
    localparam int unsigned HDG_W   = 16;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned DIST_W  = 35;
    localparam int unsigned PROD_W  = 51;
    localparam int unsigned OUT_W   = 32;

    // Reset values of the gains (Q8.8).
    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST  = 16'd64;
    localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = 16'd256;

    // CORDIC gain compensation 0.60725 in Q0.16.
    localparam logic [GAIN_W-1:0] DIST_GAIN = 16'd39797;

    // Half-turn start angle used when the error vector points left.
    localparam logic [ANG_W-1:0] ANGLE_PI = 32'h8000_0000;

    // atan(2^-i) as a 32-bit binary angle, rounded to the nearest unit.
    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ANG_W-1:0] val;
        unique case (idx)
            5'd0:  val = 32'h2000_0000;
            5'd1:  val = 32'h12E4_051E;
            5'd2:  val = 32'h09FB_385B;
            5'd3:  val = 32'h0511_11D4;
            5'd4:  val = 32'h028B_0D43;
            5'd5:  val = 32'h0145_D7E1;
            5'd6:  val = 32'h00A2_F61E;
            5'd7:  val = 32'h0051_7C55;
            5'd8:  val = 32'h0028_BE53;
            5'd9:  val = 32'h0014_5F2F;
            5'd10: val = 32'h000A_2F98;
            5'd11: val = 32'h0005_17CC;
            5'd12: val = 32'h0002_8BE6;
            5'd13: val = 32'h0001_45F3;
            5'd14: val = 32'h0000_A2FA;
            5'd15: val = 32'h0000_517D;
            5'd16: val = 32'h0000_28BE;
            5'd17: val = 32'h0000_145F;
            5'd18: val = 32'h0000_0A30;
            5'd19: val = 32'h0000_0518;
            5'd20: val = 32'h0000_028C;
            5'd21: val = 32'h0000_0146;
            5'd22: val = 32'h0000_00A3;
            5'd23: val = 32'h0000_0051;
            5'd24: val = 32'h0000_0029;
            5'd25: val = 32'h0000_0014;
            5'd26: val = 32'h0000_000A;
            5'd27: val = 32'h0000_0005;
            5'd28: val = 32'h0000_0003;
            5'd29: val = 32'h0000_0001;
            5'd30: val = 32'h0000_0001;
            5'd31: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/ggv_pose_if.sv
// Pose channel: one robot pose per transfer.
interface ggv_pose_if;
    logic                                valid;
    logic                                ready;
    logic signed [ggv_pkg::POS_W-1:0]    robot_x;
    logic signed [ggv_pkg::POS_W-1:0]    robot_y;
    logic signed [ggv_pkg::HDG_W-1:0]    robot_heading;

    modport source (output valid, output robot_x, output robot_y, output robot_heading,
                    input ready);
    modport sink   (input valid, input robot_x, input robot_y, input robot_heading,
                    output ready);
endinterface

>>> hw/rtl/ggv_cmd_if.sv
// Command channel: one velocity command per transfer.
interface ggv_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [ggv_pkg::OUT_W-1:0]    linear_speed;
    logic signed [ggv_pkg::OUT_W-1:0]    angular_rate;

    modport source (output valid, output linear_speed, output angular_rate, input ready);
    modport sink   (input valid, input linear_speed, input angular_rate, output ready);
endinterface

>>> hw/rtl/go_to_goal_velocity_core.sv
// Go-to-goal proportional velocity controller for a differential-drive robot.
//
// i_pose carries robot poses (x, y in signed Q16.16, heading as a 16-bit binary
// angle). o_cmd carries one command per pose: linear speed (unsigned Q16.16,
// saturated) and angular rate (signed, 8 fraction bits). Both are valid/ready
// channels; a transfer happens on a rising edge with valid and ready high.
// The goal and the two Q8.8 gains are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and must only change while no pose is in flight.
//
// Timing: CORDIC_STAGES + 6 register stages (error, pre-rotation, one CORDIC
// iteration per stage, three multiplier stages and the output register). One
// pose is taken every cycle unless every stage holds an item and the receiver
// holds ready low; the CORDIC depth sets the latency.
//
// Reset empties the pipeline and loads the goal (0, 0), a linear gain of 0.25
// and an angular gain of 1.0. When the receiver holds ready low, the output
// register holds its command and the stages behind it keep filling their empty
// slots; i_pose.ready drops only once every stage holds an item.
module go_to_goal_velocity_core #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ggv_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ggv_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    ggv_pose_if.sink                            i_pose,
    ggv_cmd_if.source                           o_cmd
);

    localparam int unsigned NV     = CORDIC_STAGES + 6;
    localparam int unsigned ST_M1  = CORDIC_STAGES + 2;
    localparam int unsigned ST_M2  = CORDIC_STAGES + 3;
    localparam int unsigned ST_M3  = CORDIC_STAGES + 4;
    localparam int unsigned ST_OUT = CORDIC_STAGES + 5;

    // Configuration registers.
    logic signed [ggv_pkg::POS_W-1:0]  r_goal_x;
    logic signed [ggv_pkg::POS_W-1:0]  r_goal_y;
    logic        [ggv_pkg::GAIN_W-1:0] r_lin_gain;
    logic        [ggv_pkg::GAIN_W-1:0] r_ang_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x   <= '0;
            r_goal_y   <= '0;
            r_lin_gain <= ggv_pkg::LINEAR_GAIN_RST;
            r_ang_gain <= ggv_pkg::ANGULAR_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (ggv_pkg::t_cfg_idx'(i_cfg_idx))
                ggv_pkg::CFG_GOAL_X:       r_goal_x   <= $signed(i_cfg_data[ggv_pkg::POS_W-1:0]);
                ggv_pkg::CFG_GOAL_Y:       r_goal_y   <= $signed(i_cfg_data[ggv_pkg::POS_W-1:0]);
                ggv_pkg::CFG_LINEAR_GAIN:  r_lin_gain <= i_cfg_data[ggv_pkg::GAIN_W-1:0];
                ggv_pkg::CFG_ANGULAR_GAIN: r_ang_gain <= i_cfg_data[ggv_pkg::GAIN_W-1:0];
            endcase
        end
    end

    // Stage valid bits and per-stage load enables. A stage loads when it is
    // empty or when the stage after it loads, so bubbles collapse under a stall.
    logic [NV-1:0] r_vld;
    logic [NV-1:0] n_vld;
    logic [NV-1:0] stage_en;

    always_comb begin
        stage_en[NV-1] = !r_vld[NV-1] || o_cmd.ready;
        for (int k = NV - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (stage_en[0]) begin
            n_vld[0] = i_pose.valid;
        end
        for (int k = 1; k < NV; k++) begin
            if (stage_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pose.ready = stage_en[0];

    // Stage 0: position error to the goal, exact in 33 bits.
    logic signed [ggv_pkg::ERR_W-1:0]  r_ex;
    logic signed [ggv_pkg::ERR_W-1:0]  r_ey;
    logic signed [ggv_pkg::HDG_W-1:0]  r_hd0;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_ex  <= ggv_pkg::ERR_W'(r_goal_x) - ggv_pkg::ERR_W'(i_pose.robot_x);
            r_ey  <= ggv_pkg::ERR_W'(r_goal_y) - ggv_pkg::ERR_W'(i_pose.robot_y);
            r_hd0 <= i_pose.robot_heading;
        end
    end

    // CORDIC pipeline registers; entry 0 is the pre-rotation stage.
    logic signed [ggv_pkg::XY_W-1:0]   r_cx   [0:CORDIC_STAGES];
    logic signed [ggv_pkg::XY_W-1:0]   r_cy   [0:CORDIC_STAGES];
    logic        [ggv_pkg::ANG_W-1:0]  r_cz   [0:CORDIC_STAGES];
    logic signed [ggv_pkg::HDG_W-1:0]  r_chd  [0:CORDIC_STAGES];
    logic                              r_czero[0:CORDIC_STAGES];

    // Stage 1: fold the vector into the right half plane.
    logic signed [ggv_pkg::XY_W-1:0] ex_ext;
    logic signed [ggv_pkg::XY_W-1:0] ey_ext;

    assign ex_ext = ggv_pkg::XY_W'(r_ex);
    assign ey_ext = ggv_pkg::XY_W'(r_ey);

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            if (r_ex < 0) begin
                r_cx[0] <= -ex_ext;
                r_cy[0] <= -ey_ext;
                r_cz[0] <= ggv_pkg::ANGLE_PI;
            end else begin
                r_cx[0] <= ex_ext;
                r_cy[0] <= ey_ext;
                r_cz[0] <= '0;
            end
            r_chd[0]   <= r_hd0;
            r_czero[0] <= (r_ex == '0) && (r_ey == '0);
        end
    end

    // One vectoring iteration per stage, driving y toward zero.
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
        logic signed [ggv_pkg::XY_W-1:0] xs;
        logic signed [ggv_pkg::XY_W-1:0] ys;
        logic        [ggv_pkg::ANG_W-1:0] step_ang;

        assign xs       = r_cx[gi] >>> gi;
        assign ys       = r_cy[gi] >>> gi;
        assign step_ang = ggv_pkg::atan_entry(5'(gi));

        always_ff @(posedge i_clk) begin
            if (stage_en[gi+2]) begin
                if (r_cy[gi] >= 0) begin
                    r_cx[gi+1] <= r_cx[gi] + ys;
                    r_cy[gi+1] <= r_cy[gi] - xs;
                    r_cz[gi+1] <= r_cz[gi] + step_ang;
                end else begin
                    r_cx[gi+1] <= r_cx[gi] - ys;
                    r_cy[gi+1] <= r_cy[gi] + xs;
                    r_cz[gi+1] <= r_cz[gi] - step_ang;
                end
                r_chd[gi+1]   <= r_chd[gi];
                r_czero[gi+1] <= r_czero[gi];
            end
        end
    end

    // Stage M1: gain-compensation product and wrapped heading error.
    logic [ggv_pkg::PROD_W-1:0]        r_dprod;
    logic signed [ggv_pkg::HDG_W-1:0]  r_herr;
    logic                              r_zero1;
    logic [ggv_pkg::ANG_W-1:0]         bear_z;
    logic [ggv_pkg::ANG_W-1:0]         bear_rnd;
    logic [ggv_pkg::HDG_W-1:0]         bearing;

    assign bear_z   = r_czero[CORDIC_STAGES] ? '0 : r_cz[CORDIC_STAGES];
    assign bear_rnd = bear_z + ggv_pkg::ANG_W'(32'h0000_8000);
    assign bearing  = bear_rnd[ggv_pkg::ANG_W-1 -: ggv_pkg::HDG_W];

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_M1]) begin
            r_dprod <= ggv_pkg::PROD_W'(r_cx[CORDIC_STAGES][ggv_pkg::DIST_W-1:0])
                       * ggv_pkg::PROD_W'(ggv_pkg::DIST_GAIN);
            r_herr  <= $signed(bearing - r_chd[CORDIC_STAGES]);
            r_zero1 <= r_czero[CORDIC_STAGES];
        end
    end

    // Stage M2: rounded distance and angular-rate product.
    logic [ggv_pkg::PROD_W-1:0]        dprod_rnd;
    logic [ggv_pkg::DIST_W-1:0]        r_dist;
    logic signed [ggv_pkg::OUT_W-1:0]  r_ang2;

    assign dprod_rnd = r_dprod + ggv_pkg::PROD_W'(32'h0000_8000);

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_M2]) begin
            r_dist <= r_zero1 ? '0 : dprod_rnd[16 +: ggv_pkg::DIST_W];
            r_ang2 <= ggv_pkg::OUT_W'(r_herr)
                      * ggv_pkg::OUT_W'($signed({1'b0, r_ang_gain}));
        end
    end

    // Stage M3: linear-speed product.
    logic [ggv_pkg::PROD_W-1:0]        r_lprod;
    logic signed [ggv_pkg::OUT_W-1:0]  r_ang3;

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_M3]) begin
            r_lprod <= ggv_pkg::PROD_W'(r_dist) * ggv_pkg::PROD_W'(r_lin_gain);
            r_ang3  <= r_ang2;
        end
    end

    // Output register: round and saturate the linear speed, and hold until the transfer.
    logic [ggv_pkg::PROD_W-1:0]        lprod_rnd;
    logic [ggv_pkg::PROD_W-9:0]        lin_q;
    logic [ggv_pkg::OUT_W-1:0]         r_lin;
    logic signed [ggv_pkg::OUT_W-1:0]  r_ang;

    assign lprod_rnd = r_lprod + ggv_pkg::PROD_W'(32'h0000_0080);
    assign lin_q     = lprod_rnd[ggv_pkg::PROD_W-1:8];

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_OUT]) begin
            r_lin <= (|lin_q[ggv_pkg::PROD_W-9:ggv_pkg::OUT_W])
                     ? '1 : lin_q[ggv_pkg::OUT_W-1:0];
            r_ang <= r_ang3;
        end
    end

    assign o_cmd.valid        = r_vld[ST_OUT];
    assign o_cmd.linear_speed = r_lin;
    assign o_cmd.angular_rate = r_ang;

`ifndef SYNTHESIS
    // Reset leaves the pipeline empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // An empty slot anywhere in the pipeline means a pose can be taken.
    a_ready_on_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld != '1) |-> i_pose.ready)
        else $error("input stalled while a stage is empty");

    // With the output stalled and full, the item behind it is held unchanged.
    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_OUT] && !o_cmd.ready && r_vld[ST_M3])
        |=> (r_vld[ST_M3] && $stable(r_lprod) && $stable(r_ang3)))
        else $error("item behind a stalled output was lost or changed");

    // A full pipeline with a stalled receiver refuses new poses.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_vld == '1) && !o_cmd.ready) |-> !i_pose.ready)
        else $error("pose accepted while the pipeline is full and stalled");
`endif

endmodule

>>> test/go_to_goal_velocity_core_tb.sv
`timescale 1ns / 1ps

module go_to_goal_velocity_core_tb;

    localparam int STAGES             = 16;
    localparam int LATENCY            = STAGES + 5;
    localparam int LONG_HOLD          = 4 * (STAGES + 6);
    localparam int RANDOM_PER_SETTING = 170;
    localparam int MAX_PRINTED        = 40;
    localparam longint TIMEOUT_NS     = 5_000_000;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] POS_MIN = 32'h8000_0000;

    // atan(2^-i) in binary-angle units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    typedef struct packed {
        logic signed [ggv_pkg::POS_W-1:0] x;
        logic signed [ggv_pkg::POS_W-1:0] y;
        logic signed [ggv_pkg::HDG_W-1:0] heading;
    } t_pose;

    typedef struct packed {
        logic        [ggv_pkg::OUT_W-1:0] linear_speed;
        logic signed [ggv_pkg::OUT_W-1:0] angular_rate;
    } t_cmd;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ggv_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ggv_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ggv_pose_if pose_ch ();
    ggv_cmd_if  cmd_ch ();

    go_to_goal_velocity_core #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pose    (pose_ch),
        .o_cmd     (cmd_ch)
    );

    // Register contents as the testbench believes them to be.
    logic signed [ggv_pkg::POS_W-1:0]  cur_goal_x;
    logic signed [ggv_pkg::POS_W-1:0]  cur_goal_y;
    logic        [ggv_pkg::GAIN_W-1:0] cur_linear_gain;
    logic        [ggv_pkg::GAIN_W-1:0] cur_angular_gain;

    t_pose pose_queue[$];
    t_cmd  expected_cmds[$];
    t_pose next_pose;
    t_pose seen_pose;
    t_cmd  want_cmd;

    bit pose_taken  = 1'b0;
    bit steady      = 1'b0;
    bit holdoff_req = 1'b0;
    int send_gap     = 0;
    int stall_left   = 0;
    int holdoff_left = 0;

    int mismatches    = 0;
    int poses_sent    = 0;
    int cmds_checked  = 0;
    int input_stalls  = 0;
    int settings_used = 1;

    always #5 i_clk = ~i_clk;

    // Expected command for one pose under the current goal and gains.
    function automatic t_cmd predict_command(t_pose p);
        longint         ex;
        longint         ey;
        longint         cx;
        longint         cy;
        longint         sx;
        longint         sy;
        logic [31:0]    z;
        logic [63:0]    distance;
        logic [63:0]    speed;
        logic [63:0]    rounded_z;
        logic [15:0]    bearing;
        logic signed [15:0] hdg_err;
        int             i;
        t_cmd           c;

        ex = longint'(cur_goal_x) - longint'(p.x);
        ey = longint'(cur_goal_y) - longint'(p.y);
        cx = ex;
        cy = ey;
        z  = 32'd0;
        // Fold the left half plane over so that the vectoring converges.
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            z  = 32'h8000_0000;
        end
        for (i = 0; i < STAGES; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy >= 0) begin
                cx = cx + sy;
                cy = cy - sx;
                z  = z + ATAN_TURN[i];
            end else begin
                cx = cx - sy;
                cy = cy + sx;
                z  = z - ATAN_TURN[i];
            end
        end
        // At the goal the bearing is defined as zero.
        if (ex == 0 && ey == 0) begin
            distance = 64'd0;
            z        = 32'd0;
        end else begin
            distance = (64'(cx) * 64'd39797 + 64'd32768) >> 16;
        end
        speed = (distance * 64'(cur_linear_gain) + 64'd128) >> 8;
        c.linear_speed = (speed > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : speed[31:0];
        rounded_z = {32'd0, z} + 64'h8000;
        bearing = rounded_z[31:16];
        hdg_err = bearing - p.heading;
        c.angular_rate = 32'(hdg_err) * 32'($signed({1'b0, cur_angular_gain}));
        return c;
    endfunction

    // Idle length for either side: mostly none, sometimes short, rarely long.
    function automatic int idle_length(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return 32'd0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Random pose, biased toward the goal, the axes through it and the extremes.
    function automatic t_pose random_pose();
        t_pose       p;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        p.heading = 16'($urandom);
        if ($urandom_range(0, 7) == 0)
            p.heading = 16'(pick_extreme() >> 16);
        case (sel)
            0, 1, 2, 3: begin
                p.x = cur_goal_x + 32'($urandom_range(0, 2097152)) - 32'd1048576;
                p.y = cur_goal_y + 32'($urandom_range(0, 2097152)) - 32'd1048576;
            end
            4, 5, 6: begin
                p.x = $urandom;
                p.y = $urandom;
            end
            7: begin
                if ($urandom_range(0, 1) == 0) begin
                    p.x = cur_goal_x;
                    p.y = cur_goal_y + 32'($urandom_range(0, 65536)) - 32'd32768;
                end else begin
                    p.x = cur_goal_x + 32'($urandom_range(0, 65536)) - 32'd32768;
                    p.y = cur_goal_y;
                end
            end
            8: begin
                p.x = pick_extreme();
                p.y = pick_extreme();
            end
            default: begin
                p.x = cur_goal_x;
                p.y = cur_goal_y;
            end
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        // Only the first few are printed; all of them are counted.
        if (mismatches < MAX_PRINTED)
            $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_pose(input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] h);
        t_pose p;
        p.x = x;
        p.y = y;
        p.heading = h;
        pose_queue.push_back(p);
    endtask

    task automatic write_reg(input ggv_pkg::t_cfg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            ggv_pkg::CFG_GOAL_X:       cur_goal_x       = data;
            ggv_pkg::CFG_GOAL_Y:       cur_goal_y       = data;
            ggv_pkg::CFG_LINEAR_GAIN:  cur_linear_gain  = data[15:0];
            ggv_pkg::CFG_ANGULAR_GAIN: cur_angular_gain = data[15:0];
            default: ;
        endcase
    endtask

    // Wait until no pose is pending or in flight and every command has arrived.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pose_queue.size() != 0 || pose_ch.valid || expected_cmds.size() != 0);
    endtask

    task automatic run_setting(input logic [31:0] gx, input logic [31:0] gy,
                               input logic [15:0] lg, input logic [15:0] ag,
                               input bit calm, input bit squeeze);
        wait_idle();
        write_reg(ggv_pkg::CFG_GOAL_X, gx);
        write_reg(ggv_pkg::CFG_GOAL_Y, gy);
        write_reg(ggv_pkg::CFG_LINEAR_GAIN, {16'd0, lg});
        write_reg(ggv_pkg::CFG_ANGULAR_GAIN, {16'd0, ag});
        settings_used++;
        steady = calm;
        // Robot at the goal, then as far from it as the fields allow.
        queue_pose(gx, gy, 16'h8000);
        queue_pose(gx[31] ? POS_MAX : POS_MIN, gy[31] ? POS_MAX : POS_MIN, 16'($urandom));
        if (squeeze)
            holdoff_req = 1'b1;
        repeat (RANDOM_PER_SETTING)
            pose_queue.push_back(random_pose());
    endtask

    // Pose driver: holds each item until its transfer, then idles or moves on.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pose_ch.valid <= 1'b0;
        end else if (!pose_ch.valid || pose_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                pose_ch.valid <= 1'b0;
            end else if (pose_queue.size() > 0) begin
                next_pose = pose_queue.pop_front();
                pose_ch.robot_x       <= next_pose.x;
                pose_ch.robot_y       <= next_pose.y;
                pose_ch.robot_heading <= next_pose.heading;
                pose_ch.valid         <= 1'b1;
                send_gap = idle_length(steady);
            end else begin
                pose_ch.valid <= 1'b0;
            end
        end
    end

    // Command receiver: random stalls plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.ready <= 1'b0;
        end else if (holdoff_req) begin
            holdoff_req  = 1'b0;
            holdoff_left = LONG_HOLD - 1;
            cmd_ch.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            cmd_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            cmd_ch.ready <= 1'b0;
        end else begin
            stall_left = idle_length(steady);
            if (stall_left > 0) begin
                stall_left--;
                cmd_ch.ready <= 1'b0;
            end else begin
                cmd_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each pose transfer, checks each command transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pose_ch.valid && pose_ch.ready) begin
                seen_pose.x       = pose_ch.robot_x;
                seen_pose.y       = pose_ch.robot_y;
                seen_pose.heading = pose_ch.robot_heading;
                expected_cmds.push_back(predict_command(seen_pose));
                poses_sent++;
            end else if (pose_ch.valid) begin
                input_stalls++;
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch($sformatf("command with no pose behind it: speed %h rate %h",
                                              cmd_ch.linear_speed, cmd_ch.angular_rate));
                end else begin
                    want_cmd = expected_cmds.pop_front();
                    if (cmd_ch.linear_speed !== want_cmd.linear_speed)
                        report_mismatch($sformatf("linear_speed %h, expected %h",
                                                  cmd_ch.linear_speed, want_cmd.linear_speed));
                    if (cmd_ch.angular_rate !== want_cmd.angular_rate)
                        report_mismatch($sformatf("angular_rate %h, expected %h",
                                                  cmd_ch.angular_rate, want_cmd.angular_rate));
                    cmds_checked++;
                end
            end
        end
        pose_taken <= i_rst_n && pose_ch.valid && pose_ch.ready;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d commands outstanding", expected_cmds.size());
        $display("[go_to_goal_velocity_core] ERROR");
        $finish;
    end

    // Main sequence: reset, directed poses, then a series of register settings.
    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = ggv_pkg::CFG_GOAL_X;
        i_cfg_data            = '0;
        pose_ch.valid         = 1'b0;
        pose_ch.robot_x       = '0;
        pose_ch.robot_y       = '0;
        pose_ch.robot_heading = '0;
        cmd_ch.ready          = 1'b0;
        cur_goal_x            = '0;
        cur_goal_y            = '0;
        cur_linear_gain       = ggv_pkg::LINEAR_GAIN_RST;
        cur_angular_gain      = ggv_pkg::ANGULAR_GAIN_RST;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed poses against the reset goal and gains.
        queue_pose(32'd0, 32'd0, 16'h0000);
        queue_pose(32'd0, 32'd0, 16'h7FFF);
        queue_pose(32'd0, 32'd0, 16'h8000);
        queue_pose(32'hFFFF_0000, 32'd0, 16'h0000);
        queue_pose(32'h0001_0000, 32'd0, 16'h0000);
        queue_pose(32'h0001_0000, 32'd1, 16'h8000);
        queue_pose(32'h0001_0000, 32'hFFFF_FFFF, 16'h7FFF);
        queue_pose(32'd0, 32'hFFFF_0000, 16'h4000);
        queue_pose(32'd0, 32'h0001_0000, 16'hC000);
        queue_pose(32'h0001_0000, 32'h0001_0000, 16'h0000);
        queue_pose(32'hFFFF_0000, 32'h0001_0000, 16'hFFFF);
        queue_pose(POS_MAX, POS_MAX, 16'h1234);
        queue_pose(POS_MIN, POS_MIN, 16'h8000);
        queue_pose(POS_MIN, POS_MAX, 16'h7FFF);
        queue_pose(32'd1, 32'd0, 16'h0001);
        queue_pose(32'd0, 32'd1, 16'hFFFF);

        run_setting(POS_MAX, POS_MIN, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        run_setting(POS_MIN, POS_MAX, 16'h0000, 16'h0000, 1'b0, 1'b0);
        run_setting($urandom, $urandom, 16'h0100, 16'h0001, 1'b1, 1'b1);
        run_setting(32'($urandom_range(0, 1310720)) - 32'd655360,
                    32'($urandom_range(0, 1310720)) - 32'd655360,
                    16'($urandom), 16'($urandom), 1'b0, 1'b0);
        run_setting(32'd0, 32'd0, 16'd64, 16'd256, 1'b0, 1'b0);
        run_setting($urandom, $urandom, 16'($urandom), 16'($urandom), 1'b1, 1'b0);

        // Drain, then give a stray late command time to show up.
        wait_idle();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("%0d poses driven and %0d commands checked across %0d register settings",
                 poses_sent, cmds_checked, settings_used);
        $display("input was held off for %0d cycles; %0d mismatches", input_stalls, mismatches);
        if (mismatches == 0)
            $display("[go_to_goal_velocity_core] OK");
        else
            $display("[go_to_goal_velocity_core] ERROR");
        $finish;
    end

endmodule
